// ----- hdl/bracket_nesting_checker_unit_macros.svh -----
// Assertion macros for the bracket nesting checker.
// Used by bracket_nesting_checker_unit.sv; expects clk and rst_n in scope.
`ifndef BRACKET_NESTING_CHECKER_UNIT_MACROS_SVH
`define BRACKET_NESTING_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BNC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bnc_pkg.sv -----
// Types, constants and the byte classifier for the bracket nesting checker.
// No dependencies.
package bnc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef logic [1:0]  kind_t;
    typedef logic [15:0] weight_t;
    typedef logic [31:0] total_t;

    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY  = 2'd2;
    localparam kind_t KIND_ANGLE  = 2'd3;

    localparam weight_t WEIGHT_ROUND_RST  = 16'd3;
    localparam weight_t WEIGHT_SQUARE_RST = 16'd57;
    localparam weight_t WEIGHT_CURLY_RST  = 16'd1197;
    localparam weight_t WEIGHT_ANGLE_RST  = 16'd25137;

    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;
    localparam logic [7:0] CHAR_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CHAR_ANGLE_CLOSE  = 8'h3E;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_CHAR = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_SKIPPED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_WEIGHT_ROUND  = 2'd0,
        REG_WEIGHT_SQUARE = 2'd1,
        REG_WEIGHT_CURLY  = 2'd2,
        REG_WEIGHT_ANGLE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        kind_t kind;
    } char_class_t;

    typedef struct packed {
        status_t    status;
        kind_t      expected_kind;
        weight_t    added_score;
        total_t     total_score;
        logic [6:0] open_depth;
    } result_t;

    function automatic char_class_t bnc_classify(input logic [7:0] c);
        char_class_t r;
        r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        unique case (c)
            CHAR_ROUND_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
            CHAR_SQUARE_OPEN:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            CHAR_CURLY_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
            CHAR_ANGLE_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
            CHAR_ROUND_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
            CHAR_SQUARE_CLOSE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            CHAR_CURLY_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
            CHAR_ANGLE_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
            default:           r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/bracket_nesting_checker_unit.sv -----
// Each result is registered in the output register, or in the skid entry while the
// output is held. Throughput: one byte per cycle while not stalled; the stack top
// sits in a register, the entry below it prefetched from the single-port-write stack
// memory with a write-to-read bypass. A two-entry output buffer parts the channels.
// Reset: depth, line state, total and buffers clear; weights take their defaults.
// The stack memory is not cleared: entries are always written before use.
`include "bracket_nesting_checker_unit_macros.svh"

module bracket_nesting_checker_unit
    import bnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        line_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  expected_kind,
    output logic [15:0] added_score,
    output logic [31:0] total_score,
    output logic [6:0]  open_depth
);

    kind_t stack_mem [STACK_DEPTH];

    weight_t    weight_reg [4];
    logic [CNT_W-1:0] count_reg, count_next;
    kind_t      tos_reg, tos_next;
    logic       line_failed_reg, line_failed_next;
    total_t     total_reg, total_next;
    kind_t      rd_data_reg;
    logic       fwd_valid_reg;
    kind_t      fwd_data_reg;

    result_t    out_reg, skid_reg, res;
    logic       out_valid_reg, skid_valid_reg;

    logic              accept, out_take;
    char_class_t       cls;
    kind_t             nos;
    logic [CNT_W-1:0]  cnt_after;
    kind_t             tos_after;
    logic              failed_after;
    total_t            total_after;
    weight_t           added;
    status_t           st;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [32:0]       sum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign cls      = bnc_classify(char_code);
    assign nos      = fwd_valid_reg ? fwd_data_reg : rd_data_reg;
    assign sum      = {1'b0, total_reg} + {17'd0, weight_reg[cls.kind]};

    always_comb
    begin
        st           = ST_OK;
        added        = '0;
        cnt_after    = count_reg;
        tos_after    = tos_reg;
        failed_after = line_failed_reg;
        total_after  = total_reg;
        wr_en        = 1'b0;
        if (line_failed_reg)
        begin
            st = ST_SKIPPED;
        end
        else if (cls.is_open)
        begin
            if (count_reg == CNT_W'(STACK_DEPTH))
            begin
                st           = ST_OVERFLOW;
                failed_after = 1'b1;
            end
            else
            begin
                wr_en     = (count_reg != '0);
                tos_after = cls.kind;
                cnt_after = count_reg + CNT_W'(1);
            end
        end
        else if (cls.is_close)
        begin
            if (count_reg == '0)
            begin
                st           = ST_EMPTY;
                failed_after = 1'b1;
            end
            else if (tos_reg == cls.kind)
            begin
                cnt_after = count_reg - CNT_W'(1);
                tos_after = nos;
            end
            else
            begin
                st           = ST_MISMATCH;
                added        = weight_reg[cls.kind];
                total_after  = sum[32] ? '1 : sum[31:0];
                failed_after = 1'b1;
            end
        end
        else
        begin
            st           = ST_BAD_CHAR;
            failed_after = 1'b1;
        end
    end

    always_comb
    begin
        res.status        = st;
        res.expected_kind = (cnt_after == '0) ? KIND_ROUND : tos_after;
        res.added_score   = added;
        res.total_score   = total_after;
        res.open_depth    = 7'(cnt_after);
    end

    always_comb
    begin
        count_next       = count_reg;
        tos_next         = tos_reg;
        line_failed_next = line_failed_reg;
        total_next       = total_reg;
        if (accept)
        begin
            tos_next   = tos_after;
            total_next = total_after;
            if (line_last)
            begin
                count_next       = '0;
                line_failed_next = 1'b0;
            end
            else
            begin
                count_next       = cnt_after;
                line_failed_next = failed_after;
            end
        end
    end

    assign wr_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign rd_addr = ADDR_W'(count_next - CNT_W'(2));

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
        rd_data_reg  <= stack_mem[rd_addr];
        fwd_data_reg <= tos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            tos_reg         <= KIND_ROUND;
            line_failed_reg <= 1'b0;
            total_reg       <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            tos_reg         <= tos_next;
            line_failed_reg <= line_failed_next;
            total_reg       <= total_next;
            fwd_valid_reg   <= accept && wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg[KIND_ROUND]  <= WEIGHT_ROUND_RST;
            weight_reg[KIND_SQUARE] <= WEIGHT_SQUARE_RST;
            weight_reg[KIND_CURLY]  <= WEIGHT_CURLY_RST;
            weight_reg[KIND_ANGLE]  <= WEIGHT_ANGLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_WEIGHT_ROUND:  weight_reg[KIND_ROUND]  <= cfg_data;
                REG_WEIGHT_SQUARE: weight_reg[KIND_SQUARE] <= cfg_data;
                REG_WEIGHT_CURLY:  weight_reg[KIND_CURLY]  <= cfg_data;
                REG_WEIGHT_ANGLE:  weight_reg[KIND_ANGLE]  <= cfg_data;
                default:           weight_reg[KIND_ROUND]  <= weight_reg[KIND_ROUND];
            endcase
        end
    end

    // Output buffer: main register plus skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg <= accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign expected_kind = out_reg.expected_kind;
    assign added_score   = out_reg.added_score;
    assign total_score   = out_reg.total_score;
    assign open_depth    = out_reg.open_depth;

    `BNC_ASSERT_IMPL(a_depth_bound, 1'b1, count_reg <= CNT_W'(STACK_DEPTH), "stack depth over limit")
    `BNC_ASSERT_IMPL(a_skid_order, skid_valid_reg, out_valid_reg, "skid entry without main entry")
    `BNC_ASSERT_NEXT(a_skid_fill, accept && out_valid_reg && out_stall, skid_valid_reg, "item lost on stall")
    `BNC_ASSERT_NEXT(a_line_clear, accept && line_last, count_reg == '0 && !line_failed_reg, "line state not cleared")
    `BNC_ASSERT_IMPL(a_score_status, out_valid_reg && out_reg.added_score != '0, out_reg.status == ST_MISMATCH, "score without mismatch")

endmodule

// ----- verif/bracket_nesting_checker_unit_chk.sv -----
`timescale 1ns / 1ps
// Transaction checker for bracket_nesting_checker_unit: tracks weight writes, predicts
// one verdict per accepted byte and compares each accepted result in order.
// Depends on bnc_pkg for kinds, characters, status codes and the result layout.
module bracket_nesting_checker_unit_chk
    import bnc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [7:0]       char_code,
    input  logic             line_last,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [2:0]       status,
    input  logic [1:0]       expected_kind,
    input  logic [15:0]      added_score,
    input  logic [31:0]      total_score,
    input  logic [6:0]       open_depth,
    output int unsigned      mismatch_count,
    output int unsigned      verdicts_owed
);

    weight_t     weight_tab [4];
    kind_t       open_kinds [STACK_DEPTH];
    int unsigned nest_depth;
    logic        line_broken;
    total_t      score_sum;
    result_t     verdict_q [$];

    initial mismatch_count = 0;

    task automatic report_error(input string field, input logic [31:0] got,
                                input logic [31:0] want);
        $display("%0t bnc mismatch on %s: got %0h, want %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    function automatic result_t judge_byte(input logic [7:0] c, input logic last);
        result_t     r;
        logic        opener;
        logic        closer;
        kind_t       k;
        logic [32:0] sum;
        opener = 1'b0;
        closer = 1'b0;
        k = KIND_ROUND;
        r.status = ST_OK;
        r.added_score = '0;
        case (c)
            CHAR_ROUND_OPEN:   begin opener = 1'b1; k = KIND_ROUND;  end
            CHAR_SQUARE_OPEN:  begin opener = 1'b1; k = KIND_SQUARE; end
            CHAR_CURLY_OPEN:   begin opener = 1'b1; k = KIND_CURLY;  end
            CHAR_ANGLE_OPEN:   begin opener = 1'b1; k = KIND_ANGLE;  end
            CHAR_ROUND_CLOSE:  begin closer = 1'b1; k = KIND_ROUND;  end
            CHAR_SQUARE_CLOSE: begin closer = 1'b1; k = KIND_SQUARE; end
            CHAR_CURLY_CLOSE:  begin closer = 1'b1; k = KIND_CURLY;  end
            CHAR_ANGLE_CLOSE:  begin closer = 1'b1; k = KIND_ANGLE;  end
            default:
            begin
            end
        endcase
        if (line_broken)
        begin
            r.status = ST_SKIPPED;
        end
        else if (opener)
        begin
            if (nest_depth >= STACK_DEPTH)
            begin
                r.status = ST_OVERFLOW;
                line_broken = 1'b1;
            end
            else
            begin
                open_kinds[nest_depth] = k;
                nest_depth++;
            end
        end
        else if (closer)
        begin
            if (nest_depth == 0)
            begin
                r.status = ST_EMPTY;
                line_broken = 1'b1;
            end
            else if (open_kinds[nest_depth - 1] == k)
            begin
                nest_depth--;
            end
            else
            begin
                r.status = ST_MISMATCH;
                r.added_score = weight_tab[k];
                sum = {1'b0, score_sum} + {17'b0, r.added_score};
                score_sum = sum[32] ? '1 : sum[31:0];
                line_broken = 1'b1;
            end
        end
        else
        begin
            r.status = ST_BAD_CHAR;
            line_broken = 1'b1;
        end
        r.expected_kind = (nest_depth == 0) ? KIND_ROUND : open_kinds[nest_depth - 1];
        r.total_score = score_sum;
        r.open_depth = 7'(nest_depth);
        if (last)
        begin
            nest_depth = 0;
            line_broken = 1'b0;
        end
        return r;
    endfunction

    task automatic check_verdict(input result_t want);
        if (status !== want.status)
            report_error("status", 32'(status), 32'(want.status));
        if (expected_kind !== want.expected_kind)
            report_error("expected_kind", 32'(expected_kind), 32'(want.expected_kind));
        if (added_score !== want.added_score)
            report_error("added_score", 32'(added_score), 32'(want.added_score));
        if (total_score !== want.total_score)
            report_error("total_score", total_score, want.total_score);
        if (open_depth !== want.open_depth)
            report_error("open_depth", 32'(open_depth), 32'(want.open_depth));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_tab[REG_WEIGHT_ROUND]  = WEIGHT_ROUND_RST;
            weight_tab[REG_WEIGHT_SQUARE] = WEIGHT_SQUARE_RST;
            weight_tab[REG_WEIGHT_CURLY]  = WEIGHT_CURLY_RST;
            weight_tab[REG_WEIGHT_ANGLE]  = WEIGHT_ANGLE_RST;
            nest_depth = 0;
            line_broken = 1'b0;
            score_sum = '0;
            verdict_q.delete();
            verdicts_owed <= 0;
        end
        else
        begin
            if (cfg_we)
                weight_tab[cfg_addr] = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_error("result with nothing pending", 32'(status), '0);
                else
                    check_verdict(verdict_q.pop_front());
            end
            if (in_valid && !in_stall)
                verdict_q = {verdict_q, judge_byte(char_code, line_last)};
            verdicts_owed <= verdict_q.size();
        end
    end

endmodule

// ----- verif/bracket_nesting_checker_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the bracket_nesting_checker_unit testbench: clock, reset, byte and weight
// stimulus, receiver stalls and the final verdict. Needs bnc_pkg and the checker.
module bracket_nesting_checker_unit_tb;
    import bnc_pkg::*;

    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PHASE_ITEMS    = 230;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = REG_WEIGHT_ROUND;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = '0;
    logic        line_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [1:0]  expected_kind;
    logic [15:0] added_score;
    logic [31:0] total_score;
    logic [6:0]  open_depth;

    int unsigned mismatch_count;
    int unsigned verdicts_owed;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    bit          hold_req = 1'b0;
    logic [7:0]  line_bytes [$];

    bracket_nesting_checker_unit dut (.*);

    bracket_nesting_checker_unit_chk chk (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("bracket_nesting_checker_unit_tb: errors");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] open_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_ROUND_OPEN;
            KIND_SQUARE: return CHAR_SQUARE_OPEN;
            KIND_CURLY:  return CHAR_CURLY_OPEN;
            default:     return CHAR_ANGLE_OPEN;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_ROUND_CLOSE;
            KIND_SQUARE: return CHAR_SQUARE_CLOSE;
            KIND_CURLY:  return CHAR_CURLY_CLOSE;
            default:     return CHAR_ANGLE_CLOSE;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        line_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_weights(input weight_t w [4]);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= cfg_reg_t'(i);
            cfg_data <= w[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic build_line();
        int unsigned mode;
        int unsigned n;
        int unsigned pos;
        kind_t       opened [$];
        kind_t       k;
        line_bytes.delete();
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            n = $urandom_range(62, 67);
            repeat (n)
            begin
                k = kind_t'($urandom_range(3));
                opened = {opened, k};
                line_bytes = {line_bytes, open_char(k)};
            end
            while (opened.size() > 0)
            begin
                line_bytes = {line_bytes, close_char(opened[$])};
                opened.delete(opened.size() - 1);
            end
        end
        else if (mode < 23)
        begin
            repeat ($urandom_range(1, 8))
                line_bytes = {line_bytes, 8'($urandom_range(255))};
        end
        else if (mode < 40)
        begin
            repeat ($urandom_range(1, 10))
            begin
                k = kind_t'($urandom_range(3));
                line_bytes = {line_bytes, $urandom_range(1) ? open_char(k) : close_char(k)};
            end
        end
        else
        begin
            repeat ($urandom_range(2, 16))
            begin
                if (opened.size() == 0 || (opened.size() < 6 && $urandom_range(1)))
                begin
                    k = kind_t'($urandom_range(3));
                    opened = {opened, k};
                    line_bytes = {line_bytes, open_char(k)};
                end
                else
                begin
                    line_bytes = {line_bytes, close_char(opened[$])};
                    opened.delete(opened.size() - 1);
                end
            end
            while (opened.size() > 0)
            begin
                line_bytes = {line_bytes, close_char(opened[$])};
                opened.delete(opened.size() - 1);
            end
            if ($urandom_range(99) < 30)
            begin
                pos = $urandom_range(line_bytes.size() - 1);
                line_bytes[pos] = $urandom_range(1) ? close_char(kind_t'($urandom_range(3)))
                                                    : 8'($urandom_range(255));
            end
        end
    endtask

    initial
    begin
        weight_t     w [4];
        int unsigned phase_base;
        bit          hold_done;
        bit          pause_done;

        send_idle_pct = 33;
        recv_idle_pct = 49;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(CHAR_ROUND_OPEN, 1'b0);
        send_byte(CHAR_SQUARE_OPEN, 1'b0);
        send_byte(CHAR_CURLY_OPEN, 1'b0);
        send_byte(CHAR_ANGLE_OPEN, 1'b0);
        send_byte(CHAR_ANGLE_CLOSE, 1'b0);
        send_byte(CHAR_CURLY_CLOSE, 1'b0);
        send_byte(CHAR_SQUARE_CLOSE, 1'b0);
        send_byte(CHAR_ROUND_CLOSE, 1'b1);
        send_byte(CHAR_ROUND_OPEN, 1'b0);
        send_byte(CHAR_SQUARE_CLOSE, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(CHAR_SQUARE_OPEN, 1'b0);
        send_byte(CHAR_ROUND_CLOSE, 1'b1);
        send_byte(CHAR_CURLY_OPEN, 1'b0);
        send_byte(CHAR_ANGLE_CLOSE, 1'b1);
        send_byte(CHAR_ANGLE_OPEN, 1'b0);
        send_byte(CHAR_CURLY_CLOSE, 1'b1);
        send_byte(CHAR_ROUND_CLOSE, 1'b0);
        send_byte(CHAR_ROUND_OPEN, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 49;
                    w = '{default: 16'h0000};
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 33;
                    foreach (w[i])
                        w[i] = weight_t'($urandom_range(16'hFFFF));
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    w = '{default: 16'hFFFF};
                end
            endcase
            drain_results();
            write_weights(w);
            phase_base = items_sent;
            hold_done = 1'b0;
            pause_done = 1'b0;
            while (items_sent - phase_base < PHASE_ITEMS)
            begin
                if (!hold_done && items_sent - phase_base > 60)
                begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                if (!pause_done && items_sent - phase_base > 150)
                begin
                    drain_results();
                    pause_done = 1'b1;
                end
                build_line();
                send_line();
            end
        end

        repeat (10)
        begin
            build_line();
            send_line();
        end

        drain_results();
        if (mismatch_count == 0 && verdicts_owed == 0)
            $display("bracket_nesting_checker_unit_tb: clean");
        else
            $display("bracket_nesting_checker_unit_tb: errors");
        $finish;
    end

endmodule
